>>> rtl/assert_macros.svh
// Assertion shorthands; each expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/cpc_pkg.sv
package cpc_pkg;

    localparam logic [1:0] KIND_SYNC  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] SEL_STATUS  = 2'd0;
    localparam logic [1:0] SEL_CONTROL = 2'd1;
    localparam logic [1:0] SEL_COUNT0  = 2'd2;
    localparam logic [1:0] SEL_COUNT1  = 2'd3;

    localparam logic [31:0] STATUS_READ_MASK = 32'hf0c7_9c1f;

    // status word fields
    localparam int ST_EXL     = 1;
    localparam int ST_ERL     = 2;
    localparam int ST_KSU_LO  = 3;

    // control word fields
    localparam int CT_CTE       = 31;
    localparam int CT_EXL0      = 1;
    localparam int CT_MODE0_LO  = 2;
    localparam int CT_EVT0_LO   = 5;
    localparam int CT_EXL1      = 11;
    localparam int CT_MODE1_LO  = 12;
    localparam int CT_EVT1_LO   = 15;

    localparam logic [4:0] EVT_A_LO = 5'd1;
    localparam logic [4:0] EVT_A_HI = 5'd3;
    localparam logic [4:0] EVT_B_LO = 5'd12;
    localparam logic [4:0] EVT_B_HI = 5'd15;

    typedef struct packed {
        logic [31:0] status;
        logic [31:0] control;
        logic [31:0] count0;
        logic [31:0] count1;
        logic [31:0] mark0;
        logic [31:0] mark1;
    } cpc_state_t;

    function automatic logic event_counts(input logic [4:0] evt);
        event_counts = (evt >= EVT_A_LO && evt <= EVT_A_HI) ||
                       (evt >= EVT_B_LO && evt <= EVT_B_HI);
    endfunction

endpackage

>>> rtl/cpc_if.sv
interface cpc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  reg_select;
    logic [31:0] write_data;
    logic [31:0] cycle_now;

    modport source (output valid, kind, reg_select, write_data, cycle_now, input ready);
    modport sink   (input valid, kind, reg_select, write_data, cycle_now, output ready);
    modport mon    (input valid, ready, kind, reg_select, write_data, cycle_now);
endinterface

interface cpc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
    modport mon    (input valid, ready, read_data);
endinterface

>>> rtl/cpc_update.sv
module cpc_update (
    input  cpc_pkg::cpc_state_t cur,
    input  logic [31:0]         now,
    output cpc_pkg::cpc_state_t upd
);
    import cpc_pkg::*;

    logic        run;
    logic [1:0]  ksu;
    logic        exl;
    logic        hit0;
    logic        hit1;
    logic [31:0] delta0;
    logic [31:0] delta1;

    assign run = !cur.status[ST_ERL] && cur.control[CT_CTE];
    assign ksu = cur.status[ST_KSU_LO +: 2];
    assign exl = cur.status[ST_EXL];

    assign hit0 = (cur.control[CT_MODE0_LO + 32'(ksu)] || (exl && cur.control[CT_EXL0])) &&
                  event_counts(cur.control[CT_EVT0_LO +: 5]);
    assign hit1 = (cur.control[CT_MODE1_LO + 32'(ksu)] || (exl && cur.control[CT_EXL1])) &&
                  event_counts(cur.control[CT_EVT1_LO +: 5]);

    always_comb
    begin
        delta0 = now - cur.mark0;
        delta1 = now - cur.mark1;
        // a zero delta still adds one to the counter
        if (delta0 == 32'd0)
        begin
            delta0 = 32'd1;
        end
        if (delta1 == 32'd0)
        begin
            delta1 = 32'd1;
        end
    end

    always_comb
    begin
        upd         = cur;
        upd.mark0   = now;
        upd.mark1   = now;
        if (run && hit0)
        begin
            upd.count0 = cur.count0 + delta0;
        end
        if (run && hit1)
        begin
            upd.count1 = cur.count1 + delta1;
        end
    end

endmodule

>>> rtl/cycle_performance_counters_unit.sv
// The read result is registered in the cycle after the input transfer.
// Throughput: 1 item per cycle; the counter update (subtract, add) completes in
// the accepting cycle, so the next item sees the new state at once.
// Input ready drops only while a result waits and the output is stalled.
// Reset (rst_n low, asynchronous) clears all six state words and the output valid.
module cycle_performance_counters_unit (
    input  logic      clk,
    input  logic      rst_n,
    cpc_in_if.sink    in,
    cpc_out_if.source out
);
    import cpc_pkg::*;

    cpc_state_t  state_reg;
    cpc_state_t  state_next;
    cpc_state_t  upd;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] read_data_reg;
    logic [31:0] read_data_next;
    logic        take;
    logic        do_update;

    cpc_update u_update (
        .cur (state_reg),
        .now (in.cycle_now),
        .upd (upd)
    );

    assign in.ready      = !out_valid_reg || out.ready;
    assign take          = in.valid && in.ready;
    assign out.valid     = out_valid_reg;
    assign out.read_data = read_data_reg;

    always_comb
    begin
        do_update = 1'b0;
        case (in.kind)
            KIND_SYNC:  do_update = 1'b1;
            KIND_WRITE: do_update = (in.reg_select == SEL_STATUS) ||
                                    (in.reg_select == SEL_CONTROL);
            KIND_READ:  do_update = (in.reg_select == SEL_COUNT0) ||
                                    (in.reg_select == SEL_COUNT1);
            default:    do_update = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        read_data_next = read_data_reg;
        out_valid_next = out_valid_reg && !out.ready;
        if (take)
        begin
            out_valid_next = 1'b1;
            read_data_next = 32'd0;
            if (do_update)
            begin
                state_next = upd;
            end
            if (in.kind == KIND_WRITE)
            begin
                case (in.reg_select)
                    SEL_STATUS:  state_next.status  = in.write_data;
                    SEL_CONTROL: state_next.control = in.write_data;
                    SEL_COUNT0:
                    begin
                        state_next.count0 = in.write_data;
                        state_next.mark0  = in.cycle_now;
                    end
                    default:
                    begin
                        state_next.count1 = in.write_data;
                        state_next.mark1  = in.cycle_now;
                    end
                endcase
            end
            else if (in.kind == KIND_READ)
            begin
                case (in.reg_select)
                    SEL_STATUS:  read_data_next = state_reg.status & STATUS_READ_MASK;
                    SEL_CONTROL: read_data_next = state_reg.control;
                    SEL_COUNT0:  read_data_next = upd.count0;
                    default:     read_data_next = upd.count1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
    end

endmodule

>>> rtl/cpc_checker.sv
`include "assert_macros.svh"

module cpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  in_kind,
    input logic [1:0]  in_reg_select,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_read_data
);
    import cpc_pkg::*;

    logic in_xfer;
    logic wr_xfer;
    logic st_rd_xfer;

    assign in_xfer    = in_valid && in_ready;
    assign wr_xfer    = in_xfer && (in_kind == KIND_WRITE);
    assign st_rd_xfer = in_xfer && (in_kind == KIND_READ) &&
                        (in_reg_select == SEL_STATUS);

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_valid)
    `ASSERT_NEXT(a_write_reads_zero, wr_xfer, out_read_data == 32'd0)
    `ASSERT_NEXT(a_status_masked, st_rd_xfer, (out_read_data & ~STATUS_READ_MASK) == 32'd0)
    `ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind cycle_performance_counters_unit cpc_checker u_cpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in.valid),
    .in_ready      (in.ready),
    .in_kind       (in.kind),
    .in_reg_select (in.reg_select),
    .out_valid     (out.valid),
    .out_ready     (out.ready),
    .out_read_data (out.read_data)
);

>>> tb/cycle_performance_counters_unit_tb.sv
module cycle_performance_counters_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpc_pkg::*;

    // kind 3 has no meaning to the block; it must still answer with zero
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int RANDOM_PER_PHASE = 534;
    localparam int PLAN_ROWS = 25;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  sel;
        logic [31:0] data;
        logic [31:0] now;
        bit          pinned;
        logic [31:0] want;
    } access_t;

    logic clk = 1'b0;
    logic rst_n;

    cpc_in_if  in_ch();
    cpc_out_if out_ch();

    cycle_performance_counters_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the block's registers
    logic [31:0] status_q;
    logic [31:0] control_q;
    logic [31:0] count0_q;
    logic [31:0] count1_q;
    logic [31:0] mark0_q;
    logic [31:0] mark1_q;

    logic [31:0] read_data_due[$];
    logic [31:0] cycle_clock;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          failures;
    int          results_seen;
    int          kind_seen[4];
    int          count0_adds;
    int          count1_adds;
    int          frozen_updates;

    access_t plan[PLAN_ROWS];

    task automatic note_failure(input string msg);
        if (failures < MAX_PRINTED)
            $display("[%0t] ERROR: %s", $realtime, msg);
        failures++;
    endtask

    function automatic bit event_live(input logic [4:0] e);
        return e inside {[EVT_A_LO:EVT_A_HI], [EVT_B_LO:EVT_B_HI]};
    endfunction

    function automatic logic [31:0] span_since(input logic [31:0] now, input logic [31:0] mark);
        logic [31:0] d;
        d = now - mark;
        return (d == 32'd0) ? 32'd1 : d;
    endfunction

    function automatic void tick_counters(input logic [31:0] now);
        int  ksu;
        bit  exl;
        bit  hit0;
        bit  hit1;
        ksu = int'(status_q[ST_KSU_LO +: 2]);
        exl = status_q[ST_EXL];
        if (!status_q[ST_ERL] && control_q[CT_CTE])
        begin
            hit0 = control_q[CT_MODE0_LO + ksu] || (exl && control_q[CT_EXL0]);
            hit1 = control_q[CT_MODE1_LO + ksu] || (exl && control_q[CT_EXL1]);
            if (hit0 && event_live(control_q[CT_EVT0_LO +: 5]))
            begin
                count0_q += span_since(now, mark0_q);
                count0_adds++;
            end
            if (hit1 && event_live(control_q[CT_EVT1_LO +: 5]))
            begin
                count1_q += span_since(now, mark1_q);
                count1_adds++;
            end
        end
        else
            frozen_updates++;
        mark0_q = now;
        mark1_q = now;
    endfunction

    // advance the shadow registers by one access and return the read data it yields
    function automatic logic [31:0] apply_access(input access_t a);
        logic [31:0] rd;
        rd = 32'd0;
        kind_seen[a.kind]++;
        case (a.kind)
            KIND_SYNC: tick_counters(a.now);
            KIND_WRITE:
                case (a.sel)
                    SEL_STATUS:
                    begin
                        tick_counters(a.now);
                        status_q = a.data;
                    end
                    SEL_CONTROL:
                    begin
                        tick_counters(a.now);
                        control_q = a.data;
                    end
                    SEL_COUNT0:
                    begin
                        count0_q = a.data;
                        mark0_q = a.now;
                    end
                    default:
                    begin
                        count1_q = a.data;
                        mark1_q = a.now;
                    end
                endcase
            KIND_READ:
                case (a.sel)
                    SEL_STATUS:  rd = status_q & STATUS_READ_MASK;
                    SEL_CONTROL: rd = control_q;
                    SEL_COUNT0:
                    begin
                        tick_counters(a.now);
                        rd = count0_q;
                    end
                    default:
                    begin
                        tick_counters(a.now);
                        rd = count1_q;
                    end
                endcase
            default: rd = 32'd0;
        endcase
        return rd;
    endfunction

    function automatic logic [4:0] live_event();
        int idx;
        idx = $urandom_range(6);
        return (idx < 3) ? EVT_A_LO + 5'(idx) : EVT_B_LO + 5'(idx - 3);
    endfunction

    function automatic access_t random_access();
        access_t a;
        int      r;
        r = $urandom_range(99);
        if (r < 30)
            a.kind = KIND_SYNC;
        else if (r < 60)
            a.kind = KIND_WRITE;
        else if (r < 95)
            a.kind = KIND_READ;
        else
            a.kind = KIND_SPARE;
        a.sel = 2'($urandom_range(3));
        a.data = $urandom;
        if (a.kind == KIND_WRITE)
        begin
            case (a.sel)
                SEL_STATUS:
                    if ($urandom_range(99) < 80)
                        a.data[ST_ERL] = 1'b0;
                SEL_CONTROL:
                begin
                    if ($urandom_range(99) < 85)
                        a.data[CT_CTE] = 1'b1;
                    if ($urandom_range(99) < 75)
                        a.data[CT_EVT0_LO +: 5] = live_event();
                    if ($urandom_range(99) < 75)
                        a.data[CT_EVT1_LO +: 5] = live_event();
                end
                default:
                    if ($urandom_range(9) == 0)
                        a.data = 32'hffff_fff0 + 32'($urandom_range(15));
            endcase
        end
        // mostly small steps so counters move visibly; repeats give zero spans
        r = $urandom_range(99);
        if (r < 10)
            cycle_clock = cycle_clock;
        else if (r < 90)
            cycle_clock += 32'($urandom_range(1, 40));
        else if (r < 97)
            cycle_clock += 32'($urandom_range(65536));
        else
            cycle_clock = $urandom;
        a.now = cycle_clock;
        a.pinned = 1'b0;
        a.want = 32'd0;
        return a;
    endfunction

    task automatic send_access(input access_t a);
        logic [31:0] want;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= a.kind;
        in_ch.reg_select <= a.sel;
        in_ch.write_data <= a.data;
        in_ch.cycle_now  <= a.now;
        do
            @(posedge clk);
        while (!in_ch.ready);
        want = apply_access(a);
        if (a.pinned)
            want = a.want;
        read_data_due.push_back(want);
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watch_results
        logic [31:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (read_data_due.size() == 0)
                note_failure($sformatf("read_data 0x%08h with nothing pending",
                                       out_ch.read_data));
            else
            begin
                want = read_data_due.pop_front();
                if (out_ch.read_data !== want)
                    note_failure($sformatf("read_data 0x%08h, want 0x%08h (result %0d)",
                                           out_ch.read_data, want, results_seen));
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int guard;
        status_q = '0;
        control_q = '0;
        count0_q = '0;
        count1_q = '0;
        mark0_q = '0;
        mark1_q = '0;
        failures = 0;
        results_seen = 0;
        count0_adds = 0;
        count1_adds = 0;
        frozen_updates = 0;
        kind_seen = '{default: 0};
        tx_idle_pct = 9;
        rx_idle_pct = 52;

        plan = '{
            '{KIND_READ,  SEL_STATUS,  32'h0,         32'd0,         1'b1, 32'h0},
            '{KIND_READ,  SEL_CONTROL, 32'h0,         32'd0,         1'b1, 32'h0},
            '{KIND_READ,  SEL_COUNT0,  32'h0,         32'd5,         1'b1, 32'h0},
            '{KIND_SPARE, SEL_COUNT1,  32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0},
            '{KIND_WRITE, SEL_STATUS,  32'hffff_ffff, 32'd10,        1'b1, 32'h0},
            '{KIND_READ,  SEL_STATUS,  32'h0,         32'd12,        1'b1, 32'hf0c7_9c1f},
            '{KIND_WRITE, SEL_CONTROL, 32'h8007_9024, 32'd20,        1'b1, 32'h0},
            '{KIND_SYNC,  SEL_STATUS,  32'h0,         32'd30,        1'b1, 32'h0},
            '{KIND_READ,  SEL_COUNT0,  32'h0,         32'd40,        1'b1, 32'h0},
            '{KIND_WRITE, SEL_STATUS,  32'h0,         32'd50,        1'b1, 32'h0},
            '{KIND_READ,  SEL_COUNT0,  32'h0,         32'd50,        1'b0, 32'h0},
            '{KIND_READ,  SEL_COUNT1,  32'h0,         32'h10,        1'b0, 32'h0},
            '{KIND_WRITE, SEL_COUNT0,  32'hffff_ffff, 32'd100,       1'b1, 32'h0},
            '{KIND_READ,  SEL_COUNT0,  32'h0,         32'd103,       1'b0, 32'h0},
            '{KIND_WRITE, SEL_STATUS,  32'h18,        32'd110,       1'b1, 32'h0},
            '{KIND_READ,  SEL_COUNT0,  32'h0,         32'd120,       1'b0, 32'h0},
            '{KIND_READ,  SEL_COUNT1,  32'h0,         32'd130,       1'b0, 32'h0},
            '{KIND_WRITE, SEL_STATUS,  32'h2,         32'd140,       1'b1, 32'h0},
            '{KIND_WRITE, SEL_CONTROL, 32'h8006_0882, 32'd150,       1'b1, 32'h0},
            '{KIND_READ,  SEL_COUNT0,  32'h0,         32'd160,       1'b0, 32'h0},
            '{KIND_READ,  SEL_COUNT1,  32'h0,         32'd170,       1'b0, 32'h0},
            '{KIND_WRITE, SEL_CONTROL, 32'h7fff_ffff, 32'd180,       1'b1, 32'h0},
            '{KIND_SYNC,  SEL_COUNT1,  32'hffff_ffff, 32'd200,       1'b1, 32'h0},
            '{KIND_READ,  SEL_CONTROL, 32'h0,         32'd205,       1'b1, 32'h7fff_ffff},
            '{KIND_WRITE, SEL_COUNT1,  32'h0,         32'd210,       1'b1, 32'h0}
        };

        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_SYNC;
        in_ch.reg_select <= SEL_STATUS;
        in_ch.write_data <= '0;
        in_ch.cycle_now  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_access(plan[i]);

        // start just below the wrap point so the cycle count rolls over early
        cycle_clock = 32'hffff_f000;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 52;
                end
                1:
                begin
                    tx_idle_pct = 52;
                    rx_idle_pct = 9;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE)
                send_access(random_access());
        end
        in_ch.valid <= 1'b0;

        guard = 0;
        while (read_data_due.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        if (read_data_due.size() != 0)
            note_failure($sformatf("%0d results never arrived", read_data_due.size()));

        $display("Covered %0d syncs, %0d writes, %0d reads, %0d spare-kind transfers; %0d results",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], results_seen);
        $display("Counter zero advanced %0d times, counter one %0d times, %0d frozen updates",
                 count0_adds, count1_adds, frozen_updates);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/cpc_pkg.sv
rtl/cpc_if.sv
rtl/cpc_update.sv
rtl/cycle_performance_counters_unit.sv
rtl/cpc_checker.sv
tb/cycle_performance_counters_unit_tb.sv
